@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker module of the knob menu selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define KT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define KT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ktms_pkg.sv @@
// Package with the types and constants of the knob turn menu selector.
`timescale 1ns / 1ps

package ktms_pkg;

   localparam int SUM_BITS = 14;
   localparam int SUM_MAX  = 8191;
   localparam int SUM_MIN  = -8192;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the configuration port (byte address is four times the index).
   localparam logic [2:0] REG_ENTRY_COUNT    = 3'd0;
   localparam logic [2:0] REG_QUAL_MASK      = 3'd1;
   localparam logic [2:0] REG_WRAP_LOW       = 3'd2;
   localparam logic [2:0] REG_WRAP_HIGH      = 3'd3;
   localparam logic [2:0] REG_STILL_DELTA    = 3'd4;
   localparam logic [2:0] REG_STILL_LIMIT    = 3'd5;
   localparam logic [2:0] REG_STEP_THRESHOLD = 3'd6;

   localparam logic [4:0]  RST_ENTRY_COUNT    = 5'd0;
   localparam logic [15:0] RST_QUAL_MASK      = 16'd0;
   localparam logic [11:0] RST_WRAP_LOW       = 12'd820;
   localparam logic [11:0] RST_WRAP_HIGH      = 12'd2870;
   localparam logic [11:0] RST_STILL_DELTA    = 12'd2;
   localparam logic [2:0]  RST_STILL_LIMIT    = 3'd4;
   localparam logic [12:0] RST_STEP_THRESHOLD = 13'd328;

   localparam logic [2:0] STILL_COUNT_MAX = 3'd7;

   typedef struct packed {
      logic [4:0]  entry_count;
      logic [15:0] qual_mask;
      logic [11:0] wrap_low;
      logic [11:0] wrap_high;
      logic [11:0] still_delta;
      logic [2:0]  still_limit;
      logic [12:0] step_threshold;
   } cfg_type;

   typedef struct packed {
      logic [3:0] selected_index;
      logic       is_elim;
      logic       changed;
      logic       no_entries;
   } result_type;

endpackage

@@ rtl/core/ktms_step.sv @@
// Per-sample update of the turn accumulator, stillness count and menu selection.
`timescale 1ns / 1ps

module ktms_step import ktms_pkg::*; #(
   parameter int MAX_ENTRIES = 16,
   parameter int SAMPLE_BITS = 12,
   localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
   input  cfg_type                       cfg,
   input  logic [SAMPLE_BITS-1:0]        sample,
   input  logic [SAMPLE_BITS-1:0]        prev_sample,
   input  logic                          primed,
   input  logic signed [SUM_BITS-1:0]    turn_sum,
   input  logic [2:0]                    still_count,
   input  logic [IDX_W-1:0]              sel_index,
   output logic [SAMPLE_BITS-1:0]        prev_sample_nxt,
   output logic                          primed_nxt,
   output logic signed [SUM_BITS-1:0]    turn_sum_nxt,
   output logic [2:0]                    still_count_nxt,
   output logic [IDX_W-1:0]              sel_index_nxt,
   output result_type                    result
);

   localparam int CW = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
   localparam int MW = CW + 1;
   localparam int DW = SAMPLE_BITS + 1;
   localparam int SW = ((DW > SUM_BITS) ? DW : SUM_BITS) + 1;

   logic [CW-1:0]              cur_c, prev_c, lo_c, hi_c;
   logic                       wrap_jump;
   logic signed [DW-1:0]       delta;
   logic [DW-1:0]              mag;
   logic                       delta_pos, delta_neg, sum_pos, sum_neg;
   logic signed [SUM_BITS-1:0] base;
   logic signed [SW-1:0]       raw, sat_max, sat_min;
   logic signed [SUM_BITS-1:0] sum_acc;
   logic [2:0]                 cnt_acc;
   logic [SUM_BITS-1:0]        sum_mag;
   logic [12:0]                thr;
   logic                       due;
   logic [7:0]                 ec8, max8, n8, sel8, up8, down8;
   logic [31:0]                sel32;

   always_comb begin
      cur_c  = CW'(sample);
      prev_c = CW'(prev_sample);
      lo_c   = CW'(cfg.wrap_low);
      hi_c   = CW'(cfg.wrap_high);
      wrap_jump = (cur_c < lo_c && prev_c > hi_c) || (cur_c > hi_c && prev_c < lo_c);

      delta = $signed({1'b0, sample}) - $signed({1'b0, prev_sample});
      mag   = delta[DW-1] ? DW'(-delta) : DW'(delta);

      delta_neg = delta[DW-1];
      delta_pos = !delta[DW-1] && (delta != '0);
      sum_neg   = turn_sum[SUM_BITS-1];
      sum_pos   = !turn_sum[SUM_BITS-1] && (turn_sum != '0);
      // A change of direction, a zero delta included, restarts the turn.
      base = ((delta_pos != sum_pos) || (delta_neg != sum_neg)) ? '0 : turn_sum;

      sat_max = $signed(SW'(SUM_MAX));
      sat_min = $signed(SW'(SUM_MIN));
      raw     = SW'(base) + SW'(delta);
      if (raw > sat_max) begin
         sum_acc = SUM_BITS'(sat_max);
      end else if (raw < sat_min) begin
         sum_acc = SUM_BITS'(sat_min);
      end else begin
         sum_acc = SUM_BITS'(raw);
      end

      cnt_acc = still_count;
      if (MW'(mag) < MW'(cfg.still_delta) && still_count != STILL_COUNT_MAX) begin
         cnt_acc = still_count + 3'd1;
      end
      if (cnt_acc > cfg.still_limit) begin
         cnt_acc = '0;
         sum_acc = '0;
      end

      sum_mag = sum_acc[SUM_BITS-1] ? SUM_BITS'(-sum_acc) : SUM_BITS'(sum_acc);
      thr     = (cfg.step_threshold == '0) ? 13'd1 : cfg.step_threshold;
      due     = sum_mag >= SUM_BITS'(thr);

      ec8   = 8'(cfg.entry_count);
      max8  = 8'(MAX_ENTRIES);
      n8    = (ec8 > max8) ? max8 : ec8;
      sel8  = 8'(sel_index);
      up8   = (sel8 + 8'd1 >= n8) ? 8'd0 : sel8 + 8'd1;
      down8 = (sel8 == 8'd0 || sel8 - 8'd1 >= n8) ? n8 - 8'd1 : sel8 - 8'd1;

      prev_sample_nxt   = sample;
      primed_nxt        = 1'b1;
      turn_sum_nxt      = turn_sum;
      still_count_nxt   = still_count;
      sel_index_nxt     = sel_index;
      result.changed    = 1'b0;
      result.no_entries = 1'b0;

      if (!primed) begin
         // The first sample only sets the reference level.
      end else if (wrap_jump) begin
         turn_sum_nxt    = '0;
         still_count_nxt = '0;
      end else begin
         turn_sum_nxt    = sum_acc;
         still_count_nxt = cnt_acc;
         if (due) begin
            turn_sum_nxt = '0;
            if (n8 == 8'd0) begin
               result.no_entries = 1'b1;
            end else begin
               sel_index_nxt  = sum_acc[SUM_BITS-1] ? IDX_W'(down8) : IDX_W'(up8);
               result.changed = 1'b1;
            end
         end
      end

      sel32 = 32'(sel_index_nxt);
      result.selected_index = 4'(sel_index_nxt);
      result.is_elim = (sel32 >= 32'd16) ? 1'b1 : !cfg.qual_mask[sel32[3:0]];
   end

endmodule

@@ rtl/core/knob_turn_menu_selector_core.sv @@
// Top level of the knob turn menu selector: handshakes, registers and configuration port.
`timescale 1ns / 1ps

// Usage:
// The req channel takes one raw potentiometer sample per transaction; the rsp channel
// returns one result per sample: the selected menu index, whether that entry is an
// elimination routine, whether this sample stepped the selection, and whether a step
// was due with no entries configured.
// Each sample passes an input register and then a result register, from which its result
// is offered. A new sample is accepted every cycle while the receiver takes results or a
// register is free; the turn state is updated combinationally between the two registers.
// When the receiver stalls, the result register holds its transaction and the input
// register keeps the next one; req_ready drops only when both are full.
// Configuration is written over the csr APB port (pready always high, register i at
// byte address 4*i); the user must write it only while the block is idle, which the
// block does not enforce. Reads return the stored values. Synchronous reset empties both
// registers, clears the turn state and the selection, and loads the default configuration.
module knob_turn_menu_selector_core import ktms_pkg::*; #(
   parameter int MAX_ENTRIES = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0]             rsp_selected_index,
   output logic                   rsp_is_elim,
   output logic                   rsp_changed,
   output logic                   rsp_no_entries,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);

   cfg_type                    cfg_ff, cfg_in;
   logic                       in_valid_ff;
   logic [SAMPLE_BITS-1:0]     in_sample_ff;
   logic                       out_valid_ff;
   result_type                 out_result_ff, result_in;
   logic [SAMPLE_BITS-1:0]     prev_sample_ff, prev_sample_in;
   logic                       primed_ff, primed_in;
   logic signed [SUM_BITS-1:0] turn_sum_ff, turn_sum_in;
   logic [2:0]                 still_count_ff, still_count_in;
   logic [IDX_W-1:0]           sel_index_ff, sel_index_in;
   logic                       advance, csr_write;
   logic [2:0]                 csr_index;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   ktms_step #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_step (
      .cfg             (cfg_ff),
      .sample          (in_sample_ff),
      .prev_sample     (prev_sample_ff),
      .primed          (primed_ff),
      .turn_sum        (turn_sum_ff),
      .still_count     (still_count_ff),
      .sel_index       (sel_index_ff),
      .prev_sample_nxt (prev_sample_in),
      .primed_nxt      (primed_in),
      .turn_sum_nxt    (turn_sum_in),
      .still_count_nxt (still_count_in),
      .sel_index_nxt   (sel_index_in),
      .result          (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         prev_sample_ff <= '0;
         primed_ff      <= 1'b0;
         turn_sum_ff    <= '0;
         still_count_ff <= '0;
         sel_index_ff   <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         // The turn state moves on exactly when a sample enters the result register.
         if (in_valid_ff && advance) begin
            prev_sample_ff <= prev_sample_in;
            primed_ff      <= primed_in;
            turn_sum_ff    <= turn_sum_in;
            still_count_ff <= still_count_in;
            sel_index_ff   <= sel_index_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sample_ff <= req_sample;
      end
      if (in_valid_ff && advance) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_selected_index = out_result_ff.selected_index;
   assign rsp_is_elim        = out_result_ff.is_elim;
   assign rsp_changed        = out_result_ff.changed;
   assign rsp_no_entries     = out_result_ff.no_entries;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_ENTRY_COUNT:    cfg_in.entry_count    = csr_pwdata[4:0];
            REG_QUAL_MASK:      cfg_in.qual_mask      = csr_pwdata[15:0];
            REG_WRAP_LOW:       cfg_in.wrap_low       = csr_pwdata[11:0];
            REG_WRAP_HIGH:      cfg_in.wrap_high      = csr_pwdata[11:0];
            REG_STILL_DELTA:    cfg_in.still_delta    = csr_pwdata[11:0];
            REG_STILL_LIMIT:    cfg_in.still_limit    = csr_pwdata[2:0];
            REG_STEP_THRESHOLD: cfg_in.step_threshold = csr_pwdata[12:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entry_count    <= RST_ENTRY_COUNT;
         cfg_ff.qual_mask      <= RST_QUAL_MASK;
         cfg_ff.wrap_low       <= RST_WRAP_LOW;
         cfg_ff.wrap_high      <= RST_WRAP_HIGH;
         cfg_ff.still_delta    <= RST_STILL_DELTA;
         cfg_ff.still_limit    <= RST_STILL_LIMIT;
         cfg_ff.step_threshold <= RST_STEP_THRESHOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_index)
         REG_ENTRY_COUNT:    csr_prdata = CSR_DATA_W'(cfg_ff.entry_count);
         REG_QUAL_MASK:      csr_prdata = CSR_DATA_W'(cfg_ff.qual_mask);
         REG_WRAP_LOW:       csr_prdata = CSR_DATA_W'(cfg_ff.wrap_low);
         REG_WRAP_HIGH:      csr_prdata = CSR_DATA_W'(cfg_ff.wrap_high);
         REG_STILL_DELTA:    csr_prdata = CSR_DATA_W'(cfg_ff.still_delta);
         REG_STILL_LIMIT:    csr_prdata = CSR_DATA_W'(cfg_ff.still_limit);
         REG_STEP_THRESHOLD: csr_prdata = CSR_DATA_W'(cfg_ff.step_threshold);
         default:            csr_prdata = '0;
      endcase
   end

endmodule

@@ rtl/core/ktms_checker.sv @@
// Port-level assertions for the knob turn menu selector, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ktms_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_selected_index,
   input logic       rsp_is_elim,
   input logic       rsp_changed,
   input logic       rsp_no_entries
);

   logic       req_take;
   logic       rsp_stall;
   logic       step_clash;
   logic [6:0] rsp_payload;

   assign req_take    = req_valid && req_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign step_clash  = rsp_changed && rsp_no_entries;
   assign rsp_payload = {rsp_selected_index, rsp_is_elim, rsp_changed, rsp_no_entries};

   // A stalled result transaction keeps its whole payload.
   `KT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled rsp changed")

   // A step either moves the selection or reports an empty menu, never both.
   `KT_ASSERT_IMPL(a_step_exclusive, rsp_valid, !step_clash, "changed and no_entries both set")

   // An accepted sample must be followed by a result on offer.
   `KT_ASSERT_IMPL(a_req_to_rsp, req_take, ##2 rsp_valid, "no result after accepted sample")

endmodule

bind knob_turn_menu_selector_core ktms_checker u_ktms_checker (.*);

@@ tb/knob_turn_menu_selector_core_tb.sv @@
// Self-checking testbench for the knob turn menu selector core.
`timescale 1ns / 1ps

module knob_turn_menu_selector_core_tb import ktms_pkg::*;;

   localparam int MENU_MAX    = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int CHUNKS      = 12;
   localparam int CHUNK_ITEMS = 70;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [11:0]           req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [3:0]            rsp_selected_index;
   logic                  rsp_is_elim;
   logic                  rsp_changed;
   logic                  rsp_no_entries;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Mirror of the knob state and configuration.
   cfg_type            knob_cfg;
   logic [11:0]        knob_last = '0;
   logic               knob_primed = 1'b0;
   logic signed [13:0] knob_turn = '0;
   logic [2:0]         knob_still = '0;
   logic [3:0]         knob_sel = '0;

   logic [11:0] sample_queue[$];
   result_type  pending_selections[$];
   result_type  oldest_selection;
   int          error_count = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          ready_left = 0;
   bit          ready_on = 1'b1;
   bit          steady = 1'b0;
   int          quiet_cycles = 0;

   knob_turn_menu_selector_core #(.MAX_ENTRIES(MENU_MAX), .SAMPLE_BITS(12)) dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic result_type predict_knob(logic [11:0] cur);
      int delta;
      int mag;
      int thr;
      int sum;
      int sum_mag;
      int n;
      result_type r;
      r = '0;
      if (!knob_primed) begin
         knob_primed = 1'b1;
         knob_last = cur;
      end else if ((cur < knob_cfg.wrap_low && knob_last > knob_cfg.wrap_high) ||
                   (cur > knob_cfg.wrap_high && knob_last < knob_cfg.wrap_low)) begin
         knob_turn = '0;
         knob_still = '0;
         knob_last = cur;
      end else begin
         delta = int'(cur) - int'(knob_last);
         mag = (delta < 0) ? -delta : delta;
         thr = (knob_cfg.step_threshold == 0) ? 1 : int'(knob_cfg.step_threshold);
         sum = knob_turn;
         knob_last = cur;
         // A change of direction, or a standstill, restarts the turn.
         if ((delta > 0) != (sum > 0) || (delta < 0) != (sum < 0)) sum = 0;
         sum = sum + delta;
         if (sum > SUM_MAX) sum = SUM_MAX;
         if (sum < SUM_MIN) sum = SUM_MIN;
         if (mag < int'(knob_cfg.still_delta) && knob_still != STILL_COUNT_MAX)
            knob_still = knob_still + 1'b1;
         if (knob_still > knob_cfg.still_limit) begin
            knob_still = '0;
            sum = 0;
         end
         sum_mag = (sum < 0) ? -sum : sum;
         if (sum_mag >= thr) begin
            n = (knob_cfg.entry_count > MENU_MAX) ? MENU_MAX : int'(knob_cfg.entry_count);
            if (n == 0) begin
               r.no_entries = 1'b1;
            end else if (sum > 0) begin
               knob_sel = (int'(knob_sel) + 1 >= n) ? 4'd0 : knob_sel + 1'b1;
               r.changed = 1'b1;
            end else begin
               knob_sel = (knob_sel == 0 || int'(knob_sel) - 1 >= n) ? 4'(n - 1)
                                                                    : knob_sel - 1'b1;
               r.changed = 1'b1;
            end
            sum = 0;
         end
         knob_turn = 14'(sum);
      end
      r.selected_index = knob_sel;
      r.is_elim = ~knob_cfg.qual_mask[knob_sel];
      return r;
   endfunction

   function automatic logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
         REG_ENTRY_COUNT:    return 32'(knob_cfg.entry_count);
         REG_QUAL_MASK:      return 32'(knob_cfg.qual_mask);
         REG_WRAP_LOW:       return 32'(knob_cfg.wrap_low);
         REG_WRAP_HIGH:      return 32'(knob_cfg.wrap_high);
         REG_STILL_DELTA:    return 32'(knob_cfg.still_delta);
         REG_STILL_LIMIT:    return 32'(knob_cfg.still_limit);
         REG_STEP_THRESHOLD: return 32'(knob_cfg.step_threshold);
         default:            return '0;
      endcase
   endfunction

   // Style 1 gives the lowest values, style 2 the highest, anything else typical ones.
   function automatic logic [31:0] pick_reg_value(logic [2:0] idx, int style);
      int pick;
      pick = $urandom_range(0, 99);
      case (idx)
         REG_ENTRY_COUNT:
            if (style == 1) return 0;
            else if (style == 2) return 31;
            else if (pick < 10) return 0;
            else if (pick < 25) return $urandom_range(17, 31);
            else return $urandom_range(1, 16);
         REG_QUAL_MASK:
            return (style == 1) ? 0 : (style == 2) ? 32'hFFFF : $urandom_range(0, 65535);
         REG_WRAP_LOW:
            return (style == 1) ? 0 : (style == 2) ? 4095 : $urandom_range(0, 1500);
         REG_WRAP_HIGH:
            return (style == 1) ? 0 : (style == 2) ? 4095 : $urandom_range(2500, 4095);
         REG_STILL_DELTA:
            return (style == 1) ? 0 : (style == 2) ? 4095 : $urandom_range(0, 8);
         REG_STILL_LIMIT:
            return (style == 1) ? 0 : (style == 2) ? 7 : $urandom_range(0, 7);
         REG_STEP_THRESHOLD:
            if (style == 1) return 0;
            else if (style == 2) return 8191;
            else if (pick < 10) return 0;
            else return $urandom_range(1, 500);
         default:
            return 0;
      endcase
   endfunction

   task automatic check_field(string label, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
         error_count++;
      end
   endtask

   // One APB transaction: setup cycle, then access cycle; pready is tied high.
   task automatic csr_access(logic [2:0] idx, logic write, logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      logic [31:0] readback;
      csr_access(idx, 1'b1, value, readback);
      case (idx)
         REG_ENTRY_COUNT:    knob_cfg.entry_count = value[4:0];
         REG_QUAL_MASK:      knob_cfg.qual_mask = value[15:0];
         REG_WRAP_LOW:       knob_cfg.wrap_low = value[11:0];
         REG_WRAP_HIGH:      knob_cfg.wrap_high = value[11:0];
         REG_STILL_DELTA:    knob_cfg.still_delta = value[11:0];
         REG_STILL_LIMIT:    knob_cfg.still_limit = value[2:0];
         REG_STEP_THRESHOLD: knob_cfg.step_threshold = value[12:0];
         default: ;
      endcase
      csr_access(idx, 1'b0, '0, readback);
      check_field($sformatf("register %0d", idx), int'(reg_value(idx)), int'(readback));
   endtask

   // Checked at the falling edge so that the clocked blocks have settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || pending_selections.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // A knob being turned: runs in one direction, reversals, standstills, jitter and jumps.
   task automatic queue_knob_walk(int count);
      int pos;
      int dir;
      int reach;
      int pick;
      pos = $urandom_range(0, 4095);
      dir = ($urandom_range(0, 1) == 0) ? 1 : -1;
      reach = $urandom_range(1, 300);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            pos += dir * int'($urandom_range(0, reach));
         end else if (pick < 72) begin
            dir = -dir;
            pos += dir * int'($urandom_range(1, reach));
         end else if (pick < 84) begin
            pos += int'($urandom_range(0, 2)) - 1;
         end else if (pick < 90) begin
            reach = $urandom_range(1, 600);
         end else if (pick < 95) begin
            pos = $urandom_range(0, 4095);
         end else begin
            pos = (pos > 2048) ? int'($urandom_range(0, 200)) : int'($urandom_range(3900, 4095));
         end
         if (pos < 0) begin
            pos = 0;
            dir = 1;
         end
         if (pos > 4095) begin
            pos = 4095;
            dir = -1;
         end
         sample_queue.push_back(12'(pos));
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready)
            pending_selections.push_back(predict_knob(req_sample));
         if (!req_valid || req_ready) begin
            if (gap_left != 0 || sample_queue.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left != 0) gap_left--;
            end else begin
               req_valid <= 1'b1;
               req_sample <= sample_queue.pop_front();
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 47);
                  gap_left = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // Receiver: alternating runs of ready and stall cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_left = 0;
      end else begin
         if (ready_left != 0) begin
            ready_left--;
         end else begin
            ready_on = !ready_on;
            ready_left = ready_on ? $urandom_range(0, 30) : $urandom_range(0, 6);
         end
         rsp_ready <= steady || ready_on;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_selections.size() == 0) begin
            $display("%0t: unexpected result transaction, expected none, actual index %0d",
                     $time, rsp_selected_index);
            error_count++;
         end else begin
            oldest_selection = pending_selections.pop_front();
            check_field("selected_index", oldest_selection.selected_index,
                        rsp_selected_index);
            check_field("is_elim", oldest_selection.is_elim, rsp_is_elim);
            check_field("changed", oldest_selection.changed, rsp_changed);
            check_field("no_entries", oldest_selection.no_entries, rsp_no_entries);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("knob_turn_menu_selector_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [31:0] readback;
      int          pushed;
      int          walk_len;
      knob_cfg = '{entry_count: RST_ENTRY_COUNT, qual_mask: RST_QUAL_MASK,
                   wrap_low: RST_WRAP_LOW, wrap_high: RST_WRAP_HIGH,
                   still_delta: RST_STILL_DELTA, still_limit: RST_STILL_LIMIT,
                   step_threshold: RST_STEP_THRESHOLD};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int idx = REG_ENTRY_COUNT; idx <= REG_STEP_THRESHOLD; idx++) begin
         csr_access(3'(idx), 1'b0, '0, readback);
         check_field($sformatf("register %0d", idx), int'(reg_value(3'(idx))),
                     int'(readback));
      end

      // Defaults with no entries: priming, a wrap jump, then a step that finds no entries.
      sample_queue = {12'd0, 12'd4095, 12'd3000, 12'd3000, 12'd3001};
      wait_drained();

      // Three entries, wrap band disabled: steps both ways, reversals and standstill.
      write_reg(REG_ENTRY_COUNT, 3);
      write_reg(REG_QUAL_MASK, 32'h0005);
      write_reg(REG_WRAP_LOW, 0);
      write_reg(REG_WRAP_HIGH, 4095);
      write_reg(REG_STILL_DELTA, 2);
      write_reg(REG_STILL_LIMIT, 1);
      write_reg(REG_STEP_THRESHOLD, 100);
      sample_queue = {12'd3101, 12'd3201, 12'd3301, 12'd3200, 12'd3200, 12'd3201,
                      12'd3201, 12'd3150, 12'd3100, 12'd4095, 12'd0};
      wait_drained();

      // An oversized entry count and a zero threshold: every single count steps.
      write_reg(REG_ENTRY_COUNT, 31);
      write_reg(REG_QUAL_MASK, 32'hFFFF);
      write_reg(REG_STILL_DELTA, 0);
      write_reg(REG_STILL_LIMIT, 7);
      write_reg(REG_STEP_THRESHOLD, 0);
      sample_queue = {12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6};
      wait_drained();

      // Lowering the count below the selection leaves a stale index; step down from it.
      write_reg(REG_ENTRY_COUNT, 4);
      sample_queue = {12'd5};
      wait_drained();

      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         for (int idx = REG_ENTRY_COUNT; idx <= REG_STEP_THRESHOLD; idx++)
            write_reg(3'(idx), pick_reg_value(3'(idx), chunk));
         steady = (chunk == 3);
         pushed = 0;
         while (pushed < CHUNK_ITEMS) begin
            walk_len = $urandom_range(8, 40);
            queue_knob_walk(walk_len);
            pushed += walk_len;
         end
         // The sender holds off here until every result of the chunk has come back.
         wait_drained();
         steady = 1'b0;
      end

      if (error_count == 0) begin
         $display("knob_turn_menu_selector_core regression: pass");
      end else begin
         $display("knob_turn_menu_selector_core regression: fail");
      end
      $finish;
   end

endmodule
